// File: rtl/core/signed_int_to_decimal_ascii_macros.svh
// assertion macros for the signed integer to decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define S2DEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s2dec assertion failed");
// next-cycle implication, disabled during reset
`define S2DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s2dec assertion failed");
`else
`define S2DEC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define S2DEC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/s2dec_pkg.sv
// shared constants and types of the signed integer to decimal text converter
`default_nettype none

package s2dec_pkg;

  localparam int unsigned MagW    = 32;
  localparam int unsigned Digits  = 10;
  localparam int unsigned BcdW    = 4 * Digits;
  localparam int unsigned CntW    = $clog2(MagW);
  localparam int unsigned DigIdxW = $clog2(Digits);
  localparam int unsigned LenW    = 4;
  localparam int unsigned CapW    = 8;
  localparam int unsigned CharW   = 8;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2d;
  localparam logic [CharW-1:0] CharNone  = 8'h00;

  // working pair of the shift-and-add-3 conversion
  typedef struct packed {
    logic [BcdW-1:0] bcd;
    logic [MagW-1:0] mag;
  } dab_t;

endpackage

`default_nettype wire

// File: rtl/core/s2dec_dabble.sv
// one shift-and-add-3 step of the binary to bcd conversion
`default_nettype none

module s2dec_dabble (
  input  wire s2dec_pkg::dab_t cur_i,
  output s2dec_pkg::dab_t      nxt_o
);

  logic [s2dec_pkg::BcdW-1:0] adj;

  // add 3 to every digit that is 5 or more
  always_comb begin
    for (int i = 0; i < s2dec_pkg::Digits; i++) begin
      if (cur_i.bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = cur_i.bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = cur_i.bcd[4*i +: 4];
      end
    end
  end

  // shift the binary msb into the bcd word
  assign nxt_o.bcd = {adj[s2dec_pkg::BcdW-2:0], cur_i.mag[s2dec_pkg::MagW-1]};
  assign nxt_o.mag = {cur_i.mag[s2dec_pkg::MagW-2:0], 1'b0};

endmodule

`default_nettype wire

// File: rtl/core/signed_int_to_decimal_ascii.sv
// signed 32-bit integer to decimal ascii text, one character per output word
// the first character word follows the bit-serial shift-and-add-3 loop, one pass per
//   value bit, then the prep state and the emit state; n = 1..11 output words per input word
// input ready only while idle; output register holds a word under backpressure
// reset (rst_ni low, asynchronous) returns to idle with no output word pending
`default_nettype none

module signed_int_to_decimal_ascii (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // value[31:0], capacity[39:32]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // character[7:0], length[11:8], zero[15:12]
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o   // error[0]
);

`include "signed_int_to_decimal_ascii_macros.svh"

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StPrep = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [s2dec_pkg::CntW-1:0]     cnt_q, cnt_d;
  s2dec_pkg::dab_t                work_q, work_d, work_nxt;
  logic                           neg_q, neg_d;
  logic [s2dec_pkg::CapW-1:0]     cap_q, cap_d;
  logic [s2dec_pkg::DigIdxW-1:0]  dig_q, dig_d;
  logic [s2dec_pkg::LenW-1:0]     len_q, len_d;
  logic                           err_q, err_d;
  logic                           sign_q, sign_d;
  logic                           mvalid_q, mvalid_d;
  logic [s2dec_pkg::CharW-1:0]    char_q, char_d;
  logic [s2dec_pkg::LenW-1:0]     olen_q, olen_d;
  logic                           olast_q, olast_d;
  logic                           oerr_q, oerr_d;

  logic                           s_acc;
  logic                           slot_free;
  logic [s2dec_pkg::MagW-1:0]     in_value;
  logic [s2dec_pkg::DigIdxW-1:0]  msd;
  logic [s2dec_pkg::LenW-1:0]     text_len;
  logic [3:0]                     cur_digit;

  assign in_value  = s_axis_tdata_i[31:0];
  assign s_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !mvalid_q || m_axis_tready_i;

  // shared conversion step
  s2dec_dabble u_dabble (
    .cur_i (work_q),
    .nxt_o (work_nxt)
  );

  // most significant nonzero digit, zero gives digit 0
  always_comb begin
    msd = '0;
    for (int i = 0; i < s2dec_pkg::Digits; i++) begin
      if (work_q.bcd[4*i +: 4] != 4'd0) begin
        msd = s2dec_pkg::DigIdxW'(i);
      end
    end
  end

  assign text_len  = s2dec_pkg::LenW'(msd) + 4'd1 + {3'd0, neg_q};
  assign cur_digit = work_q.bcd[4*dig_q +: 4];

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    work_d   = work_q;
    neg_d    = neg_q;
    cap_d    = cap_q;
    dig_d    = dig_q;
    len_d    = len_q;
    err_d    = err_q;
    sign_d   = sign_q;
    mvalid_d = mvalid_q;
    char_d   = char_q;
    olen_d   = olen_q;
    olast_d  = olast_q;
    oerr_d   = oerr_q;

    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (s_acc) begin
          neg_d      = in_value[s2dec_pkg::MagW-1];
          work_d.mag = in_value[s2dec_pkg::MagW-1] ? (~in_value + 32'd1) : in_value;
          work_d.bcd = '0;
          cap_d      = s_axis_tdata_i[39:32];
          cnt_d      = '0;
          state_d    = StConv;
        end
      end
      StConv: begin
        work_d = work_nxt;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == s2dec_pkg::CntW'(s2dec_pkg::MagW - 1)) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        dig_d   = msd;
        len_d   = text_len;
        err_d   = cap_q <= {4'd0, text_len};
        sign_d  = neg_q;
        state_d = StEmit;
      end
      StEmit: begin
        if (slot_free) begin
          mvalid_d = 1'b1;
          if (err_q) begin
            char_d  = s2dec_pkg::CharNone;
            olast_d = 1'b1;
            oerr_d  = 1'b1;
            olen_d  = '0;
            state_d = StIdle;
          end else if (sign_q) begin
            char_d  = s2dec_pkg::CharMinus;
            olast_d = 1'b0;
            oerr_d  = 1'b0;
            olen_d  = '0;
            sign_d  = 1'b0;
          end else begin
            char_d  = s2dec_pkg::CharZero | {4'd0, cur_digit};
            oerr_d  = 1'b0;
            if (dig_q == '0) begin
              olast_d = 1'b1;
              olen_d  = len_q;
              state_d = StIdle;
            end else begin
              olast_d = 1'b0;
              olen_d  = '0;
              dig_d   = dig_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    work_q  <= work_d;
    neg_q   <= neg_d;
    cap_q   <= cap_d;
    dig_q   <= dig_d;
    len_q   <= len_d;
    err_q   <= err_d;
    sign_q  <= sign_d;
    char_q  <= char_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  // ports
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {4'd0, olen_q, char_q};
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = oerr_q;

  // checks
  `S2DEC_ASSERT_NOW(a_err_is_last, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o && (m_axis_tdata_o == 16'd0))
  `S2DEC_ASSERT_NOW(a_len_only_last, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o, m_axis_tdata_o[11:8] == 4'd0)
  `S2DEC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

endmodule

`default_nettype wire

// File: verif/signed_int_to_decimal_ascii_tb.sv
// self-checking testbench for the signed integer to decimal ascii text converter
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned RandomItems = 196;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;

  // one conversion request; drain holds it back until all text has come out
  typedef struct {
    logic [s2dec_pkg::MagW-1:0] value;
    logic [s2dec_pkg::CapW-1:0] capacity;
    bit                         drain;
  } conv_req_t;

  // one expected output word
  typedef struct {
    logic [s2dec_pkg::CharW-1:0] ch;
    logic                        last;
    logic                        err;
    logic [s2dec_pkg::LenW-1:0]  len;
  } text_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [39:0] s_axis_tdata_i = '0;   // value[31:0], capacity[39:32]
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;        // character[7:0], length[11:8], zero[15:12]
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;        // error[0]

  conv_req_t  conv_q[$];
  text_char_t text_q[$];
  int unsigned n_total = 0;
  int unsigned n_accepted = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          word_taken = 1'b0;

  signed_int_to_decimal_ascii u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  always #(HalfPeriod) clk_i = ~clk_i;

  // characters of the text: optional sign plus decimal digits
  function automatic int unsigned text_length(logic [s2dec_pkg::MagW-1:0] value);
    logic [s2dec_pkg::MagW-1:0] mag;
    int unsigned                n;
    mag = value[s2dec_pkg::MagW-1] ? (~value + 1'b1) : value;
    n = 1;
    while (mag >= 10) begin
      mag = mag / 10;
      n++;
    end
    return n + (value[s2dec_pkg::MagW-1] ? 1 : 0);
  endfunction

  // expected text words for one accepted request
  task automatic push_decimal_text(logic [s2dec_pkg::MagW-1:0] value,
                                   logic [s2dec_pkg::CapW-1:0] capacity);
    logic [s2dec_pkg::MagW-1:0]  mag;
    logic [s2dec_pkg::CharW-1:0] rev[s2dec_pkg::Digits];
    int unsigned                 nd;
    int unsigned                 len;
    text_char_t                  w;
    mag = value[s2dec_pkg::MagW-1] ? (~value + 1'b1) : value;
    len = text_length(value);
    // text plus terminator does not fit: a lone error word
    if (capacity <= len) begin
      w = '{ch: s2dec_pkg::CharNone, last: 1'b1, err: 1'b1, len: '0};
      text_q.push_back(w);
      return;
    end
    nd = 0;
    for (int k = 0; k < s2dec_pkg::Digits; k++) begin
      if (k == 0 || mag != 0) begin
        rev[nd] = s2dec_pkg::CharZero + s2dec_pkg::CharW'(mag % 10);
        nd++;
        mag = mag / 10;
      end
    end
    w = '{ch: s2dec_pkg::CharMinus, last: 1'b0, err: 1'b0, len: '0};
    if (value[s2dec_pkg::MagW-1]) text_q.push_back(w);
    for (int k = nd - 1; k >= 0; k--) begin
      w.ch = rev[k];
      w.last = (k == 0);
      w.len = (k == 0) ? s2dec_pkg::LenW'(len) : '0;
      text_q.push_back(w);
    end
  endtask

  task automatic add_req(logic [s2dec_pkg::MagW-1:0] value,
                         logic [s2dec_pkg::CapW-1:0] capacity, bit drain);
    conv_req_t r;
    r = '{value: value, capacity: capacity, drain: drain};
    conv_q.push_back(r);
  endtask

  // idle percentages per phase: sender-light, receiver-light, then none
  function automatic int unsigned send_idle_pct();
    if (n_accepted * 3 < n_total) return 26;
    if (n_accepted * 3 < n_total * 2) return 81;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (n_accepted * 3 < n_total) return 81;
    if (n_accepted * 3 < n_total * 2) return 26;
    return 0;
  endfunction

  // input driver, changes on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || word_taken) begin
        if (conv_q.size() != 0 && (!conv_q[0].drain || text_q.size() == 0) &&
            $urandom_range(99) >= send_idle_pct()) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {conv_q[0].capacity, conv_q[0].value};
          void'(conv_q.pop_front());
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // monitor: check output words, then predict from accepted input words
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (text_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports)
          $display("%0t: unexpected word tdata=%h last=%b err=%b", $realtime,
                   m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      end else begin
        want = text_q.pop_front();
        if (m_axis_tdata_o[7:0] !== want.ch || m_axis_tdata_o[11:8] !== want.len ||
            m_axis_tdata_o[15:12] !== 4'h0 || m_axis_tlast_o !== want.last ||
            m_axis_tuser_o !== want.err) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display("%0t: mismatch exp ch=%h len=%0d last=%b err=%b got ch=%h len=%0d pad=%h last=%b err=%b",
                     $realtime, want.ch, want.len, want.last, want.err,
                     m_axis_tdata_o[7:0], m_axis_tdata_o[11:8], m_axis_tdata_o[15:12],
                     m_axis_tlast_o, m_axis_tuser_o);
        end
      end
    end
    word_taken = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (word_taken) begin
      push_decimal_text(s_axis_tdata_i[31:0], s_axis_tdata_i[39:32]);
      n_accepted++;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL signed_int_to_decimal_ascii");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [s2dec_pkg::MagW-1:0] v;
    int unsigned                len;
    int unsigned                pick;
    int unsigned                cap;

    // directed: zero, one-digit and carry boundaries, sign, extremes, exact fit
    add_req(32'd0, 8'd0, 1'b0);
    add_req(32'd0, 8'd1, 1'b0);
    add_req(32'd0, 8'd2, 1'b0);
    add_req(32'd0, 8'd255, 1'b0);
    add_req(32'd1, 8'd2, 1'b0);
    add_req(32'd9, 8'd2, 1'b0);
    add_req(32'd10, 8'd3, 1'b0);
    add_req(32'd10, 8'd2, 1'b0);
    add_req(-32'sd1, 8'd3, 1'b0);
    add_req(-32'sd1, 8'd2, 1'b0);
    add_req(-32'sd9, 8'd3, 1'b0);
    add_req(-32'sd10, 8'd4, 1'b0);
    add_req(32'd99, 8'd3, 1'b0);
    add_req(32'd100, 8'd4, 1'b0);
    add_req(32'h7fff_ffff, 8'd11, 1'b0);
    add_req(32'h7fff_ffff, 8'd10, 1'b0);
    add_req(32'h8000_0000, 8'd12, 1'b0);
    add_req(32'h8000_0000, 8'd11, 1'b0);
    add_req(32'h8000_0001, 8'd12, 1'b0);
    add_req(32'd1000000000, 8'd11, 1'b0);
    add_req(32'd999999999, 8'd10, 1'b0);
    add_req(-32'sd123456789, 8'd255, 1'b0);
    add_req(32'd5, 8'd1, 1'b0);
    add_req(32'h8000_0000, 8'd255, 1'b1);

    // random: magnitudes spread over every length, capacities mostly just fitting
    for (int i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(99);
      if (pick < 10) v = $urandom;
      else begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(1)) v = ~v + 1'b1;
      end
      len = text_length(v);
      pick = $urandom_range(99);
      if (pick < 15) cap = $urandom_range(0, len);
      else if (pick < 30) cap = $urandom_range(0, 255);
      else cap = len + 1 + $urandom_range(0, 3);
      add_req(v, s2dec_pkg::CapW'(cap), (i % 40) == 39);
    end
    n_total = conv_q.size();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (conv_q.size() != 0 || s_axis_tvalid_i || text_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatch_cnt == 0 && text_q.size() == 0) begin
      $display("PASS signed_int_to_decimal_ascii");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii");
    end
    $finish;
  end

endmodule
